[design/qaq_pkg.sv]
// ----------------------------------------------------------------------------
// Quad angle quality package
// Payload types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qaq_pkg;

    typedef struct packed {
        logic signed [31:0] corner0_x;
        logic signed [31:0] corner0_y;
        logic signed [31:0] corner1_x;
        logic signed [31:0] corner1_y;
        logic signed [31:0] corner2_x;
        logic signed [31:0] corner2_y;
        logic signed [31:0] corner3_x;
        logic signed [31:0] corner3_y;
    } t_quad_in;

    typedef struct packed {
        logic signed [15:0] quality;
        logic               is_concave;
        logic               is_degenerate;
    } t_quad_out;

    localparam int CORDIC_STEPS = 24;
    localparam int SC_W         = 30;   // scaled edge component
    localparam int SCALE_MSB    = 28;   // larger component lands in [2^28, 2^29)
    localparam int PROD_W       = 2 * SC_W;
    localparam int DOT_W        = PROD_W + 1;
    localparam int CW_W         = 64;   // CORDIC x and y
    localparam int Z_W          = 28;   // CORDIC angle, Q.24 radians
    localparam int TH_W         = 18;   // corner angle, Q2.16
    localparam int SUM_W        = TH_W + 2;
    localparam int D_W          = 17;
    localparam int NUM_W        = 31;
    localparam int F_W          = 15;   // Q14 factor, at most 1.0
    localparam int RECIP_SHIFT  = 32;
    localparam int RP_W         = NUM_W + 16;
    localparam int M_W          = 32;

    typedef logic signed [CW_W-1:0] t_cword;
    typedef logic signed [Z_W-1:0]  t_zang;

    localparam logic signed [Z_W-1:0]  PI_HALF_Q24  = 28'sd26353589;
    localparam logic signed [Z_W-1:0]  PI_Q24       = 28'sd52707179;
    localparam logic [SUM_W-1:0]       TWO_PI_Q16   = 20'd411775;
    localparam longint                 HALF_PI_Q16  = 102944;
    localparam logic [15:0]            RECIP_HALF_PI = 16'((64'd1 << RECIP_SHIFT) / HALF_PI_Q16);
    localparam logic [F_W-1:0]         Q14_HALF     = 15'd8192;
    localparam logic signed [15:0]     BAD_QUALITY  = -16'sd16384;
    localparam logic [15:0]            TOL_RESET    = 16'd7;

    function automatic logic [Z_W-1:0] atan_q24(input int unsigned idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 28'd13176795;
            1:       v = 28'd7778716;
            2:       v = 28'd4110060;
            3:       v = 28'd2086331;
            4:       v = 28'd1047214;
            5:       v = 28'd524117;
            6:       v = 28'd262123;
            7:       v = 28'd131069;
            default: v = (idx < 24) ? (28'd1 << (24 - idx)) : 28'd0;
        endcase
        return v;
    endfunction

endpackage

[design/quad_angle_quality.sv]
// ----------------------------------------------------------------------------
// Quad angle quality
// Angle-based quality of one quadrilateral per beat, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one quadrilateral per beat (four corners, signed Q16.16)
// and returns one quality beat per input beat, in order. It accepts a new
// beat every clock cycle while the pipeline has room. A result is valid on
// the output once it reaches the last stage and leaves at the next edge at
// which the output side is ready. The depth is set by the 24-stage CORDIC
// that turns each corner's dot and cross product into an angle, plus edge
// normalization, the 30x30 products and the factor chain. Each stage
// holds its own valid bit and moves when the stage after it has room, so a
// stall on the output fills bubbles first and never drops or repeats a beat.
// The tolerance register is written through its own channel, which is always
// ready; write it only while no beat is in flight.
// ----------------------------------------------------------------------------
module quad_angle_quality import qaq_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_quad_in    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_quad_out   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int EW = COORD_WIDTH + 1;    // edge component width
    localparam int PW = $clog2(EW);         // bit position within an edge

    // Stage indices along the pipeline.
    localparam int ST_EDGE  = 0;
    localparam int ST_MSB   = 1;
    localparam int ST_SCALE = 2;
    localparam int ST_MUL   = 3;
    localparam int ST_DOT   = 4;
    localparam int ST_CINIT = 5;
    localparam int ST_CEND  = ST_CINIT + CORDIC_STEPS;
    localparam int ST_THETA = ST_CEND + 1;
    localparam int ST_SUM   = ST_THETA + 1;
    localparam int ST_NUM   = ST_SUM + 1;
    localparam int ST_RMUL  = ST_NUM + 1;
    localparam int ST_QEST  = ST_RMUL + 1;
    localparam int ST_FAC   = ST_QEST + 1;
    localparam int ST_P1    = ST_FAC + 1;
    localparam int ST_P2    = ST_P1 + 1;
    localparam int ST_P3    = ST_P2 + 1;
    localparam int NST      = ST_P3 + 1;

    // ------------------------------------------------------------------
    // Flow control: a stage advances when it is empty or its successor
    // advances.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_v;
    logic [NST:0]   w_adv;
    logic [NST-1:0] r_dg;     // degenerate flag traveling with each beat
    logic [NST-1:0] r_cc;     // concave flag, meaningful from ST_NUM on
    logic [15:0]    r_tol;

    always_comb begin
        w_adv[NST] = i_out_ready;
        for (int s = NST - 1; s >= 0; s--) begin
            w_adv[s] = !r_v[s] || w_adv[s+1];
        end
    end

    assign o_in_ready  = w_adv[ST_EDGE];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= '0;
            r_tol <= TOL_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            for (int s = 0; s < NST; s++) begin
                if (w_adv[s]) begin
                    r_v[s] <= (s == 0) ? i_in_valid : r_v[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Edge vectors. Each coordinate is read as a COORD_WIDTH-bit two's
    // complement value.
    // ------------------------------------------------------------------
    logic [31:0]             w_raw [8];
    logic signed [COORD_WIDTH-1:0] w_c [8];
    logic signed [EW-1:0]    n_ex1 [4];
    logic signed [EW-1:0]    n_ey1 [4];
    logic                    w_dg0;
    logic signed [EW-1:0]    r_ex1 [4];
    logic signed [EW-1:0]    r_ey1 [4];

    assign w_raw[0] = i_in.corner0_x;
    assign w_raw[1] = i_in.corner0_y;
    assign w_raw[2] = i_in.corner1_x;
    assign w_raw[3] = i_in.corner1_y;
    assign w_raw[4] = i_in.corner2_x;
    assign w_raw[5] = i_in.corner2_y;
    assign w_raw[6] = i_in.corner3_x;
    assign w_raw[7] = i_in.corner3_y;

    always_comb begin
        w_dg0 = 1'b0;
        for (int j = 0; j < 8; j++) begin
            w_c[j] = COORD_WIDTH'(w_raw[j]);
        end
        for (int k = 0; k < 4; k++) begin
            n_ex1[k] = EW'(w_c[2*((k+1)%4)])   - EW'(w_c[2*k]);
            n_ey1[k] = EW'(w_c[2*((k+1)%4)+1]) - EW'(w_c[2*k+1]);
            if (n_ex1[k] == '0 && n_ey1[k] == '0) begin
                w_dg0 = 1'b1;
            end
        end
    end

    // Degenerate flag and the edge stage.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NST; s++) begin
            if (w_adv[s]) begin
                r_dg[s] <= (s == 0) ? w_dg0 : r_dg[s-1];
            end
        end
        if (w_adv[ST_EDGE]) begin
            r_ex1 <= n_ex1;
            r_ey1 <= n_ey1;
        end
    end

    // ------------------------------------------------------------------
    // Normalization: find the top bit of the larger magnitude, then shift
    // both components so that bit lands at SCALE_MSB. A right shift is a
    // floor division.
    // ------------------------------------------------------------------
    logic signed [EW-1:0] r_ex2 [4];
    logic signed [EW-1:0] r_ey2 [4];
    logic [PW-1:0]        r_p2  [4];
    logic [PW-1:0]        n_p2  [4];
    logic [EW-1:0]        w_ma  [4];
    logic [EW-1:0]        w_mb  [4];
    logic [EW-1:0]        w_mm  [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_ma[k] = r_ex1[k][EW-1] ? EW'(-r_ex1[k]) : EW'(r_ex1[k]);
            w_mb[k] = r_ey1[k][EW-1] ? EW'(-r_ey1[k]) : EW'(r_ey1[k]);
            w_mm[k] = (w_ma[k] > w_mb[k]) ? w_ma[k] : w_mb[k];
            n_p2[k] = '0;
            for (int b = 0; b < EW; b++) begin
                if (w_mm[k][b]) begin
                    n_p2[k] = PW'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_MSB]) begin
            r_ex2 <= r_ex1;
            r_ey2 <= r_ey1;
            r_p2  <= n_p2;
        end
    end

    logic signed [SC_W-1:0] r_sx [4];
    logic signed [SC_W-1:0] r_sy [4];
    logic signed [SC_W-1:0] n_sx [4];
    logic signed [SC_W-1:0] n_sy [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_p2[k] >= PW'(SCALE_MSB)) begin
                n_sx[k] = SC_W'(r_ex2[k] >>> (r_p2[k] - PW'(SCALE_MSB)));
                n_sy[k] = SC_W'(r_ey2[k] >>> (r_p2[k] - PW'(SCALE_MSB)));
            end else begin
                n_sx[k] = SC_W'(r_ex2[k]) <<< (PW'(SCALE_MSB) - r_p2[k]);
                n_sy[k] = SC_W'(r_ey2[k]) <<< (PW'(SCALE_MSB) - r_p2[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SCALE]) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
    end

    // ------------------------------------------------------------------
    // Dot and cross products of each edge with the next one.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_pxx [4];
    logic signed [PROD_W-1:0] r_pyy [4];
    logic signed [PROD_W-1:0] r_pxy [4];
    logic signed [PROD_W-1:0] r_pyx [4];
    logic signed [DOT_W-1:0]  r_dot [4];
    logic signed [DOT_W-1:0]  r_crs [4];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (w_adv[ST_MUL]) begin
                r_pxx[k] <= r_sx[k] * r_sx[(k+1)%4];
                r_pyy[k] <= r_sy[k] * r_sy[(k+1)%4];
                r_pxy[k] <= r_sx[k] * r_sy[(k+1)%4];
                r_pyx[k] <= r_sy[k] * r_sx[(k+1)%4];
            end
            if (w_adv[ST_DOT]) begin
                r_dot[k] <= DOT_W'(r_pxx[k]) + DOT_W'(r_pyy[k]);
                r_crs[k] <= DOT_W'(r_pxy[k]) - DOT_W'(r_pyx[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC start: angle of (x, y) = (-dot, |cross|). A negative x is
    // rotated by a quarter turn first.
    // ------------------------------------------------------------------
    t_cword r_cx [4];
    t_cword r_cy [4];
    t_zang  r_cz [4];
    t_cword n_cx [4];
    t_cword n_cy [4];
    t_zang  n_cz [4];
    t_cword w_x0 [4];
    t_cword w_y0 [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_x0[k] = -CW_W'(r_dot[k]);
            w_y0[k] = r_crs[k][DOT_W-1] ? -CW_W'(r_crs[k]) : CW_W'(r_crs[k]);
            if (w_x0[k][CW_W-1]) begin
                n_cx[k] = w_y0[k];
                n_cy[k] = -w_x0[k];
                n_cz[k] = PI_HALF_Q24;
            end else begin
                n_cx[k] = w_x0[k];
                n_cy[k] = w_y0[k];
                n_cz[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_CINIT]) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
            r_cz <= n_cz;
        end
    end

    t_zang w_zend [4];

    qaq_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (w_adv[ST_CINIT+1 +: CORDIC_STEPS]),
        .i_x   (r_cx),
        .i_y   (r_cy),
        .i_z   (r_cz),
        .o_z   (w_zend)
    );

    // ------------------------------------------------------------------
    // Angle clamp to [0, pi] and rounding to Q2.16.
    // ------------------------------------------------------------------
    logic [TH_W-1:0] r_th [4];
    logic [TH_W-1:0] n_th [4];
    t_zang           w_zc [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (w_zend[k][Z_W-1]) begin
                w_zc[k] = '0;
            end else if (w_zend[k] > PI_Q24) begin
                w_zc[k] = PI_Q24;
            end else begin
                w_zc[k] = w_zend[k];
            end
            n_th[k] = TH_W'((w_zc[k] + t_zang'(128)) >>> 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_THETA]) begin
            r_th <= n_th;
        end
    end

    // ------------------------------------------------------------------
    // Angle sum and distance of each corner from a right angle.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] r_sum;
    logic [D_W-1:0]   r_d [4];
    logic [D_W-1:0]   n_d [4];
    logic signed [TH_W:0] w_dd [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_dd[k] = (TH_W+1)'(HALF_PI_Q16) - $signed({1'b0, r_th[k]});
            n_d[k]  = w_dd[k][TH_W] ? D_W'(-w_dd[k]) : D_W'(w_dd[k]);
            if (n_d[k] > D_W'(HALF_PI_Q16)) begin
                n_d[k] = D_W'(HALF_PI_Q16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SUM]) begin
            r_sum <= SUM_W'(r_th[0]) + SUM_W'(r_th[1]) + SUM_W'(r_th[2])
                   + SUM_W'(r_th[3]);
            r_d   <= n_d;
        end
    end

    // Concave test and the numerator of each corner factor.
    logic [NUM_W-1:0]     r_num [4];
    logic signed [SUM_W:0] w_dev;
    logic [SUM_W-1:0]     w_adev;
    logic                 w_cc;

    assign w_dev  = $signed({1'b0, r_sum}) - $signed({1'b0, TWO_PI_Q16});
    assign w_adev = w_dev[SUM_W] ? SUM_W'(-w_dev) : SUM_W'(w_dev);
    assign w_cc   = w_adev >= SUM_W'(r_tol);

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NST; s++) begin
            if (w_adv[s]) begin
                if (s == ST_NUM) begin
                    r_cc[s] <= w_cc;
                end else if (s > ST_NUM) begin
                    r_cc[s] <= r_cc[s-1];
                end else begin
                    r_cc[s] <= 1'b0;
                end
            end
        end
        if (w_adv[ST_NUM]) begin
            for (int k = 0; k < 4; k++) begin
                r_num[k] <= (NUM_W'(D_W'(HALF_PI_Q16) - r_d[k]) << 14)
                          + NUM_W'(HALF_PI_Q16 / 2);
            end
        end
    end

    // ------------------------------------------------------------------
    // Division by pi/2: reciprocal multiply, then one correction step.
    // ------------------------------------------------------------------
    logic [RP_W-1:0]  r_rp   [4];
    logic [NUM_W-1:0] r_num3 [4];
    logic [F_W-1:0]   r_q0   [4];
    logic [M_W-1:0]   r_m    [4];
    logic [NUM_W-1:0] r_num4 [4];
    logic [F_W-1:0]   r_f    [4];
    logic [M_W-1:0]   w_rem  [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_rem[k] = M_W'(r_num4[k]) - r_m[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (w_adv[ST_RMUL]) begin
                r_rp[k]   <= RP_W'(r_num[k]) * RP_W'(RECIP_HALF_PI);
                r_num3[k] <= r_num[k];
            end
            if (w_adv[ST_QEST]) begin
                r_q0[k]   <= r_rp[k][RECIP_SHIFT +: F_W];
                r_m[k]    <= M_W'(r_rp[k][RECIP_SHIFT +: F_W]) * M_W'(HALF_PI_Q16);
                r_num4[k] <= r_num3[k];
            end
            if (w_adv[ST_FAC]) begin
                r_f[k] <= r_q0[k] + F_W'(w_rem[k] >= M_W'(HALF_PI_Q16));
            end
        end
    end

    // ------------------------------------------------------------------
    // Product of the four factors, rounded half up after each multiply.
    // The first factor times 1.0 is the factor itself.
    // ------------------------------------------------------------------
    localparam int PP_W = 2 * F_W;

    logic [F_W-1:0] r_pr1, r_pr2, r_pr3;
    logic [F_W-1:0] r_f2a, r_f3a, r_f3b;

    function automatic logic [F_W-1:0] qmul(input logic [F_W-1:0] a,
                                            input logic [F_W-1:0] b);
        logic [PP_W-1:0] pp;
        pp = PP_W'(a) * PP_W'(b) + PP_W'(Q14_HALF);
        return F_W'(pp >> 14);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_P1]) begin
            r_pr1 <= qmul(r_f[0], r_f[1]);
            r_f2a <= r_f[2];
            r_f3a <= r_f[3];
        end
        if (w_adv[ST_P2]) begin
            r_pr2 <= qmul(r_pr1, r_f2a);
            r_f3b <= r_f3a;
        end
        if (w_adv[ST_P3]) begin
            r_pr3 <= qmul(r_pr2, r_f3b);
        end
    end

    // ------------------------------------------------------------------
    // Result. A degenerate element reports only the degenerate flag.
    // ------------------------------------------------------------------
    assign o_out_valid           = r_v[ST_P3];
    assign o_out.is_degenerate   = r_dg[ST_P3];
    assign o_out.is_concave      = r_cc[ST_P3] && !r_dg[ST_P3];
    assign o_out.quality         = (r_cc[ST_P3] || r_dg[ST_P3]) ? BAD_QUALITY
                                                                : 16'(r_pr3);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.is_concave && o_out.is_degenerate))
        else $error("concave and degenerate flagged together");

    a_bad_quality: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.is_concave || o_out.is_degenerate)
            |-> o_out.quality == BAD_QUALITY)
        else $error("flagged element without bad quality");

    a_quality_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.is_concave && !o_out.is_degenerate
            |-> !o_out.quality[15] && o_out.quality <= 16'sd16384)
        else $error("quality out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_v[ST_EDGE] && $countones(r_v) == NST)
        else $error("input stalled while a pipeline stage is empty");

endmodule

[design/qaq_cordic.sv]
// ----------------------------------------------------------------------------
// Quad angle quality CORDIC
// Four vectoring CORDIC lanes, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module qaq_cordic import qaq_pkg::*; (
    input  logic                    i_clk,
    input  logic [CORDIC_STEPS-1:0] i_en,
    input  t_cword                  i_x [4],
    input  t_cword                  i_y [4],
    input  t_zang                   i_z [4],
    output t_zang                   o_z [4]
);

    t_cword r_x [CORDIC_STEPS][4];
    t_cword r_y [CORDIC_STEPS][4];
    t_zang  r_z [CORDIC_STEPS][4];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        t_cword w_x [4];
        t_cword w_y [4];
        t_zang  w_z [4];
        t_cword n_x [4];
        t_cword n_y [4];
        t_zang  n_z [4];

        if (i == 0) begin : g_src_in
            assign w_x = i_x;
            assign w_y = i_y;
            assign w_z = i_z;
        end else begin : g_src_reg
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
        end

        always_comb begin
            for (int k = 0; k < 4; k++) begin
                if (!w_y[k][CW_W-1]) begin
                    n_x[k] = w_x[k] + (w_y[k] >>> i);
                    n_y[k] = w_y[k] - (w_x[k] >>> i);
                    n_z[k] = w_z[k] + t_zang'(atan_q24(i));
                end else begin
                    n_x[k] = w_x[k] - (w_y[k] >>> i);
                    n_y[k] = w_y[k] + (w_x[k] >>> i);
                    n_z[k] = w_z[k] - t_zang'(atan_q24(i));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[i]) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
            end
        end
    end

    assign o_z = r_z[CORDIC_STEPS-1];

endmodule

[tb/sv/quad_angle_quality_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quad angle quality checker
// Watches the input, output and tolerance channels of the block. It predicts
// the quality beat of every accepted quadrilateral and compares each output
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module quad_angle_quality_checker import qaq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_quad_in    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_quad_out   i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam longint HALF_PI_Z = 26353589;
    localparam longint PI_Z      = 52707179;
    localparam longint TWO_PI_A  = 411775;
    localparam longint HALF_PI_A = 102944;
    localparam longint ONE_Q14   = 16384;
    localparam longint NORM_LO   = 64'sd1 <<< 28;
    localparam longint NORM_HI   = 64'sd1 <<< 29;

    localparam longint ARCTAN [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic [15:0] tolerance;
    t_quad_out   quality_queue[$];

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Vectoring CORDIC for y >= 0, giving the angle in Q2.16.
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = HALF_PI_Z;
        end
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN[i];
            end
        end
        if (z < 0) z = 0;
        if (z > PI_Z) z = PI_Z;
        return (z + 128) >>> 8;
    endfunction

    function automatic t_quad_out predict_quality(t_quad_in q, logic [15:0] tol);
        longint    px[4], py[4], ex[4], ey[4], theta[4];
        longint    m, dot, crs, sum, dev, d, f, prod;
        logic      flat;
        t_quad_out r;
        px[0] = q.corner0_x; py[0] = q.corner0_y;
        px[1] = q.corner1_x; py[1] = q.corner1_y;
        px[2] = q.corner2_x; py[2] = q.corner2_y;
        px[3] = q.corner3_x; py[3] = q.corner3_y;
        flat = 1'b0;
        for (int k = 0; k < 4; k++) begin
            ex[k] = px[(k + 1) % 4] - px[k];
            ey[k] = py[(k + 1) % 4] - py[k];
            if (ex[k] == 0 && ey[k] == 0) flat = 1'b1;
        end
        r.quality = BAD_QUALITY;
        r.is_concave = 1'b0;
        r.is_degenerate = 1'b0;
        if (flat) begin
            r.is_degenerate = 1'b1;
            return r;
        end
        // Bring each edge to a common scale before the products.
        for (int k = 0; k < 4; k++) begin
            m = magnitude(ex[k]) > magnitude(ey[k]) ? magnitude(ex[k]) : magnitude(ey[k]);
            while (m >= NORM_HI) begin
                ex[k] = ex[k] >>> 1;
                ey[k] = ey[k] >>> 1;
                m = m >>> 1;
            end
            while (m < NORM_LO) begin
                ex[k] = ex[k] * 2;
                ey[k] = ey[k] * 2;
                m = m * 2;
            end
        end
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            dot = ex[k] * ex[(k + 1) % 4] + ey[k] * ey[(k + 1) % 4];
            crs = ex[k] * ey[(k + 1) % 4] - ey[k] * ex[(k + 1) % 4];
            theta[k] = vector_angle(magnitude(crs), -dot);
            sum = sum + theta[k];
        end
        dev = magnitude(sum - TWO_PI_A);
        if (dev >= longint'(tol)) begin
            r.is_concave = 1'b1;
            return r;
        end
        prod = ONE_Q14;
        for (int k = 0; k < 4; k++) begin
            d = magnitude(HALF_PI_A - theta[k]);
            if (d > HALF_PI_A) d = HALF_PI_A;
            f = ((HALF_PI_A - d) * ONE_Q14 + HALF_PI_A / 2) / HALF_PI_A;
            prod = (prod * f + 8192) >>> 14;
        end
        r.quality = 16'(prod);
        return r;
    endfunction

    assign o_pending = quality_queue.size();

    always @(posedge i_clk) begin
        t_quad_out want;
        if (!i_rst_n) begin
            tolerance <= TOL_RESET;
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) tolerance <= i_cfg_data;
            if (i_in_valid && i_in_ready)
                quality_queue = {quality_queue, predict_quality(i_in, tolerance)};
            if (i_out_valid && i_out_ready) begin
                if (quality_queue.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, i_out);
                    o_errors <= o_errors + 1;
                end else begin
                    want = quality_queue.pop_front();
                    if (want.quality !== i_out.quality ||
                        want.is_concave !== i_out.is_concave ||
                        want.is_degenerate !== i_out.is_degenerate) begin
                        $display("%0t: expected q=%0d c=%b d=%b, actual q=%0d c=%b d=%b",
                                 $time, want.quality, want.is_concave, want.is_degenerate,
                                 i_out.quality, i_out.is_concave, i_out.is_degenerate);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/quad_angle_quality_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quad angle quality testbench
// Drives quadrilaterals into the block under several tolerance settings and
// idle patterns, while a checker predicts and compares every quality beat.
// ----------------------------------------------------------------------------
module quad_angle_quality_test;
    import qaq_pkg::*;

    localparam int DRAIN_CYCLES = 60;     // comfortably past the pipeline depth
    localparam int STALL_LIMIT  = 5000;   // cycles with no beat before giving up
    localparam int PHASE_ITEMS  = 214;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, well past the pipe depth

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_quad_in    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_quad_out   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    int errors;
    int pending;
    int idle_cycles;
    // Idle pattern: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
    int idle_mode;
    logic hold_request;
    int   hold_count;

    quad_angle_quality DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    quad_angle_quality_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // The receiver stalls at random according to the idle pattern. When a
    // hold-off is requested it keeps ready low for a long stretch so that the
    // pipeline fills and pushes back on the sender.
    always @(posedge i_clk) begin
        if (hold_request) begin
            i_out_ready <= 1'b0;
            hold_count = hold_count + 1;
            if (hold_count >= HOLD_CYCLES) begin
                hold_request = 1'b0;
                hold_count = 0;
            end
        end else if (idle_mode == 2) begin
            i_out_ready <= ($urandom_range(99) >= 67);
        end else if (idle_mode == 3) begin
            i_out_ready <= ($urandom_range(99) >= 32);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // The watchdog counts cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Presents one quadrilateral, first idling the sender according to the
    // pattern, and returns once the beat has been taken.
    task automatic send_quad(input t_quad_in quad);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 67 : (idle_mode == 3) ? 32 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= quad;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic make_quad(input longint xs[4], input longint ys[4], output t_quad_in q);
        q.corner0_x = 32'(xs[0]); q.corner0_y = 32'(ys[0]);
        q.corner1_x = 32'(xs[1]); q.corner1_y = 32'(ys[1]);
        q.corner2_x = 32'(xs[2]); q.corner2_y = 32'(ys[2]);
        q.corner3_x = 32'(xs[3]); q.corner3_y = 32'(ys[3]);
    endtask

    // Drains the block, waits out the pipeline, then writes the tolerance.
    task automatic set_tolerance(input logic [15:0] tol);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= tol;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // A random quadrilateral. Most are convex shapes built around a center
    // with a random size, so that the angle and factor paths are reached;
    // the rest are raw noise, repeated corners and crossed (bowtie) shapes.
    task automatic random_quad(output t_quad_in q);
        longint xs[4], ys[4], cx, cy, r, j, t;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            q = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
            return;
        end
        r = longint'(1) <<< $urandom_range(26, 2);
        r = r + longint'($urandom_range(32'(r)));
        cx = longint'($signed($urandom)) >>> 1;
        cy = longint'($signed($urandom)) >>> 1;
        j = (r >>> 2) + 1;
        xs[0] = cx + r;  ys[0] = cy;
        xs[1] = cx;      ys[1] = cy + r;
        xs[2] = cx - r;  ys[2] = cy;
        xs[3] = cx;      ys[3] = cy - r;
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(3) != 0) begin
                xs[k] = xs[k] + longint'($urandom_range(32'(2 * j))) - j;
                ys[k] = ys[k] + longint'($urandom_range(32'(2 * j))) - j;
            end
        end
        if (pick < 20) begin
            xs[1] = xs[0];
            ys[1] = ys[0];
        end else if (pick < 28) begin
            t = xs[1]; xs[1] = xs[2]; xs[2] = t;
            t = ys[1]; ys[1] = ys[2]; ys[2] = t;
        end
        make_quad(xs, ys, q);
    endtask

    task automatic directed_quads();
        longint xs[4], ys[4];
        longint one, big, bmin;
        t_quad_in q;
        one = 65536;
        big = 64'sh7fffffff;
        bmin = -64'sh80000000;
        // Unit square, both orientations.
        xs = '{0, one, one, 0};     ys = '{0, 0, one, one};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{0, 0, one, one};     ys = '{0, one, one, 0};
        make_quad(xs, ys, q); send_quad(q);
        // Smallest square and a thin rectangle.
        xs = '{0, 1, 1, 0};         ys = '{0, 0, 1, 1};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{0, 1000 * one, 1000 * one, 0}; ys = '{0, 0, 1, 1};
        make_quad(xs, ys, q); send_quad(q);
        // Corners at the extremes of the coordinate range.
        xs = '{bmin, big, big, bmin}; ys = '{bmin, bmin, big, big};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{big, bmin, bmin, big}; ys = '{big, big, bmin, bmin};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{bmin, big, 0, bmin}; ys = '{0, bmin, big, big};
        make_quad(xs, ys, q); send_quad(q);
        // Parallelogram and a kite.
        xs = '{0, 2 * one, 3 * one, one}; ys = '{0, 0, one, one};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{0, one, 0, -one};    ys = '{-one, 0, 3 * one, 0};
        make_quad(xs, ys, q); send_quad(q);
        // Concave dart and a crossed bowtie.
        xs = '{0, 2 * one, one, 0}; ys = '{0, 0, one / 4, 2 * one};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{0, one, 0, one};     ys = '{0, one, one, 0};
        make_quad(xs, ys, q); send_quad(q);
        // Zero-length edges: one edge, every corner equal, all at the extremes.
        xs = '{0, 0, one, 0};       ys = '{0, 0, one, one};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{5, 5, 5, 5};         ys = '{7, 7, 7, 7};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{big, big, big, big}; ys = '{bmin, bmin, bmin, bmin};
        make_quad(xs, ys, q); send_quad(q);
        // Collinear corners, giving straight angles.
        xs = '{0, one, 2 * one, one}; ys = '{0, 0, 0, one};
        make_quad(xs, ys, q); send_quad(q);
        xs = '{0, one, 2 * one, 3 * one}; ys = '{0, 0, 0, 0};
        make_quad(xs, ys, q); send_quad(q);
        // All ones and all zeros apart from one corner.
        q = {8{32'hffffffff}}; send_quad(q);
        q = '0; q.corner2_x = 32'h1; send_quad(q);
    endtask

    initial begin
        logic [15:0] tol_list[5];
        t_quad_in q;
        tol_list = '{16'd7, 16'd0, 16'd65535, 16'd1, 16'd300};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        idle_mode = 0;
        idle_cycles = 0;
        hold_request = 1'b0;
        hold_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Each phase waits for every expected beat before its tolerance
        // write, which also gives the sender a full pause until drained.
        for (int phase = 0; phase < 5; phase++) begin
            set_tolerance(tol_list[phase]);
            idle_mode = phase % 4;
            for (int m = 0; m < 2; m++) begin
                directed_quads();
                idle_mode = 0;
            end
            idle_mode = phase % 4;
            if (phase == 2) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) idle_mode = (phase + 1) % 4;
                random_quad(q);
                send_quad(q);
            end
        end
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
design/qaq_pkg.sv
design/qaq_cordic.sv
design/quad_angle_quality.sv
tb/sv/quad_angle_quality_checker.sv
tb/sv/quad_angle_quality_test.sv
